>>> hdl/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

   localparam logic [7:0] ACK_BYTE  = 8'hFA;
   localparam logic [7:0] HDR_MASK  = 8'hC8;
   localparam logic [7:0] HDR_MATCH = 8'h08;
   localparam int         BTN_BIT    = 0;
   localparam int         X_SIGN_BIT = 4;
   localparam int         Y_SIGN_BIT = 5;

   localparam int BYTE_W  = 8;
   localparam int DELTA_W = 9;
   localparam int POS_W   = 12;
   localparam int SENS_W  = 8;
   localparam int STEP_W  = 8;
   localparam int PROD_W  = DELTA_W + SENS_W;
   localparam int QUOT_W  = 11;

   // divide by 100: multiply by ceil(2^24 / 100), keep the bits from bit 24 up
   localparam int                PERCENT     = 100;
   localparam int                RECIP_SHIFT = 24;
   localparam int                RECIP_W     = 18;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((2 ** RECIP_SHIFT) + PERCENT - 1) / PERCENT);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [SENS_W-1:0] SENS_RESET     = 8'd80;
   localparam logic [STEP_W-1:0] MAX_STEP_RESET = 8'd15;
   localparam logic [POS_W-1:0]  SCREEN_X_RESET = 12'd1023;
   localparam logic [POS_W-1:0]  SCREEN_Y_RESET = 12'd767;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS     = 2'd0,
      CSR_MAX_STEP = 2'd1,
      CSR_SCREEN_X = 2'd2,
      CSR_SCREEN_Y = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_BTN_DOWN = 2'd0,
      EV_BTN_UP   = 2'd1,
      EV_MOVE     = 2'd2
   } event_kind_type;

   typedef enum logic [3:0] {
      PH_ACK = 4'b0001,
      PH_HDR = 4'b0010,
      PH_XB  = 4'b0100,
      PH_YB  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic btn_ev;
      logic btn_down;
      logic move;
   } pkt_info_type;

   typedef struct packed {
      logic [1:0]                event_kind;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic                      last;
   } rsp_entry_type;

endpackage

>>> hdl/ps2mpt_req_if.sv
// Request channel: one PS/2 data byte per request.
interface ps2mpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

>>> hdl/ps2mpt_rsp_if.sv
// Result channel: button and pointer-move events.
interface ps2mpt_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic signed [8:0] delta_x;
   logic signed [8:0] delta_y;
   logic [11:0]       pos_x;
   logic [11:0]       pos_y;
   logic              last;

   modport source (output valid, output event_kind, output delta_x, output delta_y,
                   output pos_x, output pos_y, output last, input ready);
   modport sink (input valid, input event_kind, input delta_x, input delta_y,
                 input pos_x, input pos_y, input last, output ready);
endinterface

>>> hdl/ps2_mouse_packet_tracker_unit.sv
// PS/2 mouse packet tracker: frames packets, emits button and move events.
// Throughput: one request per cycle; ready drops only when fewer than two of the
// 8 result-queue slots are free, counting two held per packet in the scale pipeline.
// A packet's results pass the scale pipeline stages (magnitude*scale, divide by
// 100, clamp/saturate) and are written to the result queue before being offered;
// a second result follows from the queue once the first is taken.
// Synchronous active-high reset: awaits acknowledge, pointer at 0, queue empty.
module ps2_mouse_packet_tracker_unit import ps2mpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ps2mpt_req_if.sink            req_chan,
   ps2mpt_rsp_if.source          rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SENS_W-1:0] sens_ff;
   logic [STEP_W-1:0] max_step_ff;
   logic [POS_W-1:0]  scr_x_ff, scr_y_ff;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] xbyte_ff, xbyte_in;
   logic              left_ff, left_in;
   logic [POS_W-1:0]  ptr_x_ff, ptr_x_in, ptr_y_ff, ptr_y_in;

   logic                      req_accept, pkt_end;
   logic [BYTE_W-1:0]         rx_byte;
   logic signed [DELTA_W-1:0] raw_x, raw_y;
   pkt_info_type              info_in;

   logic                      s1_vld_ff, s2_vld_ff, s3_vld_ff;
   pkt_info_type              s1_info_ff, s2_info_ff, s3_info_ff;
   logic signed [DELTA_W-1:0] s1_dx_ff, s1_dy_ff, s2_dx_ff, s2_dy_ff, s3_dx_ff, s3_dy_ff;
   logic [DELTA_W-1:0]        mag_x, mag_y;
   logic [PROD_W-1:0]         s2_prod_x_ff, s2_prod_x_in, s2_prod_y_ff, s2_prod_y_in;
   logic [PROD_W+RECIP_W-1:0] quot_x_full, quot_y_full;
   logic [QUOT_W-1:0]         s3_q_x_ff, s3_q_y_ff;

   logic [STEP_W-1:0]         step_x, step_y;
   logic signed [POS_W+1:0]   sum_x, sum_y, step_x_s, step_y_s;

   rsp_entry_type             fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]      cnt_ff;
   logic [RSP_CNT_W:0]        committed;
   rsp_entry_type             btn_entry, move_entry, head;
   logic                      rsp_pop;
   logic [1:0]                push_n;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff     <= SENS_RESET;
         max_step_ff <= MAX_STEP_RESET;
         scr_x_ff    <= SCREEN_X_RESET;
         scr_y_ff    <= SCREEN_Y_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SENS:     sens_ff     <= csr_wdata[SENS_W-1:0];
            CSR_MAX_STEP: max_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_SCREEN_X: scr_x_ff    <= csr_wdata[POS_W-1:0];
            CSR_SCREEN_Y: scr_y_ff    <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // packet framing
   assign req_accept = req_chan.valid & req_chan.ready;
   assign rx_byte    = req_chan.data_byte;
   assign raw_x      = {header_ff[X_SIGN_BIT], xbyte_ff};
   assign raw_y      = {header_ff[Y_SIGN_BIT], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      left_in   = left_ff;
      pkt_end   = 1'b0;
      if (req_accept) begin
         case (phase_ff)
            PH_ACK: begin
               if (rx_byte == ACK_BYTE) phase_in = PH_HDR;
            end
            PH_HDR: begin
               if ((rx_byte & HDR_MASK) == HDR_MATCH) begin
                  header_in = rx_byte;
                  phase_in  = PH_XB;
               end
            end
            PH_XB: begin
               xbyte_in = rx_byte;
               phase_in = PH_YB;
            end
            PH_YB: begin
               pkt_end  = 1'b1;
               left_in  = header_ff[BTN_BIT];
               phase_in = PH_HDR;
            end
            default: phase_in = PH_ACK;
         endcase
      end
      info_in.btn_ev   = header_ff[BTN_BIT] != left_ff;
      info_in.btn_down = header_ff[BTN_BIT];
      info_in.move     = (raw_x != '0) || (raw_y != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ACK;
         header_ff <= '0;
         xbyte_ff  <= '0;
         left_ff   <= 1'b0;
         ptr_x_ff  <= '0;
         ptr_y_ff  <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         xbyte_ff  <= xbyte_in;
         left_ff   <= left_in;
         ptr_x_ff  <= ptr_x_in;
         ptr_y_ff  <= ptr_y_in;
         s1_vld_ff <= pkt_end;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // scale pipeline: |d| * sensitivity, then divide by 100
   assign mag_x = s1_dx_ff[DELTA_W-1] ? DELTA_W'(-s1_dx_ff) : DELTA_W'(s1_dx_ff);
   assign mag_y = s1_dy_ff[DELTA_W-1] ? DELTA_W'(-s1_dy_ff) : DELTA_W'(s1_dy_ff);
   assign s2_prod_x_in = {{SENS_W{1'b0}}, mag_x} * {{DELTA_W{1'b0}}, sens_ff};
   assign s2_prod_y_in = {{SENS_W{1'b0}}, mag_y} * {{DELTA_W{1'b0}}, sens_ff};
   assign quot_x_full  = {{RECIP_W{1'b0}}, s2_prod_x_ff} * {{PROD_W{1'b0}}, RECIP_MULT};
   assign quot_y_full  = {{RECIP_W{1'b0}}, s2_prod_y_ff} * {{PROD_W{1'b0}}, RECIP_MULT};

   always_ff @(posedge clock) begin
      s1_info_ff   <= info_in;
      s1_dx_ff     <= raw_x;
      s1_dy_ff     <= raw_y;
      s2_info_ff   <= s1_info_ff;
      s2_dx_ff     <= s1_dx_ff;
      s2_dy_ff     <= s1_dy_ff;
      s2_prod_x_ff <= s2_prod_x_in;
      s2_prod_y_ff <= s2_prod_y_in;
      s3_info_ff   <= s2_info_ff;
      s3_dx_ff     <= s2_dx_ff;
      s3_dy_ff     <= s2_dy_ff;
      s3_q_x_ff    <= quot_x_full[RECIP_SHIFT +: QUOT_W];
      s3_q_y_ff    <= quot_y_full[RECIP_SHIFT +: QUOT_W];
   end

   // clamp, pointer update with saturation
   assign step_x = (s3_q_x_ff > QUOT_W'(max_step_ff)) ? max_step_ff : s3_q_x_ff[STEP_W-1:0];
   assign step_y = (s3_q_y_ff > QUOT_W'(max_step_ff)) ? max_step_ff : s3_q_y_ff[STEP_W-1:0];
   assign step_x_s = $signed({{(POS_W+2-STEP_W){1'b0}}, step_x});
   assign step_y_s = $signed({{(POS_W+2-STEP_W){1'b0}}, step_y});
   assign sum_x = $signed({2'b00, ptr_x_ff}) + (s3_dx_ff[DELTA_W-1] ? -step_x_s : step_x_s);
   assign sum_y = $signed({2'b00, ptr_y_ff}) + (s3_dy_ff[DELTA_W-1] ? step_y_s : -step_y_s);

   always_comb begin
      ptr_x_in = ptr_x_ff;
      ptr_y_in = ptr_y_ff;
      if (s3_vld_ff && s3_info_ff.move) begin
         if (sum_x < 0)
            ptr_x_in = '0;
         else if (sum_x > $signed({2'b00, scr_x_ff}))
            ptr_x_in = scr_x_ff;
         else
            ptr_x_in = sum_x[POS_W-1:0];
         if (sum_y < 0)
            ptr_y_in = '0;
         else if (sum_y > $signed({2'b00, scr_y_ff}))
            ptr_y_in = scr_y_ff;
         else
            ptr_y_in = sum_y[POS_W-1:0];
      end
   end

   always_comb begin
      btn_entry.event_kind  = s3_info_ff.btn_down ? EV_BTN_DOWN : EV_BTN_UP;
      btn_entry.delta_x     = s3_dx_ff;
      btn_entry.delta_y     = s3_dy_ff;
      btn_entry.pos_x       = '0;
      btn_entry.pos_y       = '0;
      btn_entry.last        = ~s3_info_ff.move;
      move_entry.event_kind = EV_MOVE;
      move_entry.delta_x    = '0;
      move_entry.delta_y    = '0;
      move_entry.pos_x      = ptr_x_in;
      move_entry.pos_y      = ptr_y_in;
      move_entry.last       = 1'b1;
      push_n = '0;
      if (s3_vld_ff)
         push_n = {1'b0, s3_info_ff.btn_ev} + {1'b0, s3_info_ff.move};
   end

   // result queue; two slots are held for every packet in flight
   always_ff @(posedge clock) begin
      if (s3_vld_ff) begin
         if (s3_info_ff.btn_ev) begin
            fifo_ff[wr_ptr_ff] <= btn_entry;
            if (s3_info_ff.move) fifo_ff[wr_ptr_ff + 1'b1] <= move_entry;
         end else if (s3_info_ff.move) begin
            fifo_ff[wr_ptr_ff] <= move_entry;
         end
      end
   end

   assign rsp_pop = rsp_chan.valid & rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push_n);
         rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(rsp_pop);
         cnt_ff    <= cnt_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(rsp_pop);
      end
   end

   assign committed = {1'b0, cnt_ff}
                    + {{(RSP_CNT_W-1){1'b0}}, s1_vld_ff, 1'b0}
                    + {{(RSP_CNT_W-1){1'b0}}, s2_vld_ff, 1'b0}
                    + {{(RSP_CNT_W-1){1'b0}}, s3_vld_ff, 1'b0};
   assign req_chan.ready = committed <= (RSP_CNT_W+1)'(RSP_DEPTH - 2);

   assign head                = fifo_ff[rd_ptr_ff];
   assign rsp_chan.valid      = cnt_ff != '0;
   assign rsp_chan.event_kind = head.event_kind;
   assign rsp_chan.delta_x    = head.delta_x;
   assign rsp_chan.delta_y    = head.delta_y;
   assign rsp_chan.pos_x      = head.pos_x;
   assign rsp_chan.pos_y      = head.pos_y;
   assign rsp_chan.last       = head.last;

endmodule

>>> hdl/ps2mpt_checker.sv
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
module ps2mpt_checker import ps2mpt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_event_kind,
   input logic signed [8:0] rsp_delta_x,
   input logic signed [8:0] rsp_delta_y,
   input logic [11:0]       rsp_pos_x,
   input logic [11:0]       rsp_pos_y,
   input logic              rsp_last
);

   // a stalled result holds its kind, position and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_last))
      else $error("stalled result changed");

   // queue is empty right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // moves close a request and carry no deltas
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_MOVE |->
         rsp_last && rsp_delta_x == '0 && rsp_delta_y == '0)
      else $error("malformed move event");

   // button events carry no position and no other code appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_MOVE |->
         (rsp_event_kind == EV_BTN_DOWN || rsp_event_kind == EV_BTN_UP) &&
         rsp_pos_x == '0 && rsp_pos_y == '0)
      else $error("malformed button event");

   // a button event that is not last is followed at once by its move
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_event_kind != EV_MOVE && !rsp_last |=>
         rsp_valid && rsp_event_kind == EV_MOVE)
      else $error("move event missing after button event");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_ps2mpt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_event_kind (rsp_chan.event_kind),
   .rsp_delta_x    (rsp_chan.delta_x),
   .rsp_delta_y    (rsp_chan.delta_y),
   .rsp_pos_x      (rsp_chan.pos_x),
   .rsp_pos_y      (rsp_chan.pos_y),
   .rsp_last       (rsp_chan.last)
);

>>> bench/tb_top.sv
// Self-checking testbench for the PS/2 mouse packet tracker unit.
module tb_top;
   import ps2mpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 10;
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [1:0] TRK_ACK = 2'd0;
   localparam logic [1:0] TRK_HDR = 2'd1;
   localparam logic [1:0] TRK_XB  = 2'd2;
   localparam logic [1:0] TRK_YB  = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ps2mpt_req_if req ();
   ps2mpt_rsp_if rsp ();

   ps2_mouse_packet_tracker_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req),
      .rsp_chan     (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tracker state and register copies
   logic [1:0]        trk_phase = TRK_ACK;
   logic [7:0]        trk_hdr   = '0;
   logic [7:0]        trk_xb    = '0;
   logic              trk_btn   = 1'b0;
   logic [POS_W-1:0]  trk_px    = '0;
   logic [POS_W-1:0]  trk_py    = '0;
   logic [SENS_W-1:0] cfg_sens  = SENS_RESET;
   logic [STEP_W-1:0] cfg_step  = MAX_STEP_RESET;
   logic [POS_W-1:0]  cfg_max_x = SCREEN_X_RESET;
   logic [POS_W-1:0]  cfg_max_y = SCREEN_Y_RESET;

   logic [7:0]    byte_queue[$];
   rsp_entry_type event_queue[$];

   int n_fail       = 0;
   int n_req        = 0;
   int n_checked    = 0;
   int n_btn_events = 0;
   int n_moves      = 0;
   int n_settings   = 0;
   int idle_cycles  = 0;
   int hold_asks    = 0;
   int hold_grants  = 0;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int scale_motion(int d);
      int s;
      s = d * int'(cfg_sens) / PERCENT;
      return clamp_int(s, -int'(cfg_step), int'(cfg_step));
   endfunction

   function automatic void track_byte(logic [7:0] b);
      int            x;
      int            y;
      logic          btn;
      logic          moved;
      rsp_entry_type ev;
      case (trk_phase)
         TRK_ACK: begin
            if (b == ACK_BYTE) trk_phase = TRK_HDR;
         end
         TRK_HDR: begin
            if ((b & HDR_MASK) == HDR_MATCH) begin
               trk_hdr   = b;
               trk_phase = TRK_XB;
            end
         end
         TRK_XB: begin
            trk_xb    = b;
            trk_phase = TRK_YB;
         end
         TRK_YB: begin
            x = trk_hdr[X_SIGN_BIT] ? int'(trk_xb) - 256 : int'(trk_xb);
            y = trk_hdr[Y_SIGN_BIT] ? int'(b) - 256 : int'(b);
            btn = trk_hdr[BTN_BIT];
            moved = (x != 0) || (y != 0);
            trk_phase = TRK_HDR;
            if (btn != trk_btn) begin
               ev = '0;
               ev.event_kind = btn ? EV_BTN_DOWN : EV_BTN_UP;
               ev.delta_x = DELTA_W'(x);
               ev.delta_y = DELTA_W'(y);
               ev.last = !moved;
               event_queue.push_back(ev);
               trk_btn = btn;
               n_btn_events++;
            end
            if (moved) begin
               trk_px = POS_W'(clamp_int(int'(trk_px) + scale_motion(x), 0, int'(cfg_max_x)));
               trk_py = POS_W'(clamp_int(int'(trk_py) - scale_motion(y), 0, int'(cfg_max_y)));
               ev = '0;
               ev.event_kind = EV_MOVE;
               ev.pos_x = trk_px;
               ev.pos_y = trk_py;
               ev.last = 1'b1;
               event_queue.push_back(ev);
               n_moves++;
            end
         end
         default: ;
      endcase
   endfunction

   // request driver: bursts with random gaps
   int   burst_left = 0;
   int   gap_left   = 0;
   logic sent;

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         sent = req.valid && req.ready;
         if (sent) begin
            track_byte(req.data_byte);
            byte_queue.delete(0);
            n_req++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!req.valid || sent) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req.valid <= 1'b1;
               req.data_byte <= byte_queue[0];
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold
   int   rx_cycle = 0;
   int   rx_mode  = 0;
   int   hold_cnt = 0;
   logic ready_n;

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (hold_grants != hold_asks) begin
            hold_cnt = LONG_HOLD;
            hold_grants++;
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         if (hold_cnt > 0) begin
            hold_cnt--;
            ready_n = 1'b0;
         end else begin
            case (rx_mode)
               0: ready_n = 1'b1;
               1: ready_n = 1'($urandom_range(0, 1));
               2: ready_n = (rx_cycle % 4 == 0);
               default: ready_n = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp.ready <= ready_n;
      end
   end

   // result monitor
   rsp_entry_type want;

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (event_queue.size() == 0) begin
            $error("unexpected event: kind %0d", rsp.event_kind);
            n_fail++;
         end else begin
            want = event_queue.pop_front();
            n_checked++;
            if (rsp.event_kind !== want.event_kind) begin
               $error("event_kind mismatch: expected %0d, actual %0d",
                      want.event_kind, rsp.event_kind);
               n_fail++;
            end
            if (rsp.delta_x !== want.delta_x) begin
               $error("delta_x mismatch: expected %0d, actual %0d", want.delta_x, rsp.delta_x);
               n_fail++;
            end
            if (rsp.delta_y !== want.delta_y) begin
               $error("delta_y mismatch: expected %0d, actual %0d", want.delta_y, rsp.delta_y);
               n_fail++;
            end
            if (rsp.pos_x !== want.pos_x) begin
               $error("pos_x mismatch: expected %0d, actual %0d", want.pos_x, rsp.pos_x);
               n_fail++;
            end
            if (rsp.pos_y !== want.pos_y) begin
               $error("pos_y mismatch: expected %0d, actual %0d", want.pos_y, rsp.pos_y);
               n_fail++;
            end
            if (rsp.last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp.last);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("ps2_mouse_packet_tracker_unit test failed");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SENS:     cfg_sens = val[SENS_W-1:0];
         CSR_MAX_STEP: cfg_step = val[STEP_W-1:0];
         CSR_SCREEN_X: cfg_max_x = val;
         default:      cfg_max_y = val;
      endcase
   endtask

   task automatic apply_setting(input int sens, input int step, input int mx, input int my);
      write_reg(CSR_SENS, CSR_DATA_W'(sens));
      write_reg(CSR_MAX_STEP, CSR_DATA_W'(step));
      write_reg(CSR_SCREEN_X, CSR_DATA_W'(mx));
      write_reg(CSR_SCREEN_Y, CSR_DATA_W'(my));
      n_settings++;
   endtask

   task automatic settle();
      while (!(byte_queue.size() == 0 && !req.valid && event_queue.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_delta();
      case ($urandom_range(0, 9))
         0, 1:    return 0;
         2, 3, 4, 5, 6: return int'($urandom_range(0, 40)) - 20;
         7:       return ($urandom_range(0, 1) != 0) ? 255 : -256;
         default: return int'($urandom_range(0, 511)) - 256;
      endcase
   endfunction

   function automatic void add_packet(input logic full);
      int         dx;
      int         dy;
      logic [7:0] hdr;
      dx = pick_delta();
      dy = pick_delta();
      hdr = HDR_MATCH;
      hdr[X_SIGN_BIT] = (dx < 0);
      hdr[Y_SIGN_BIT] = (dy < 0);
      hdr[2:0] = 3'($urandom_range(0, 7));
      byte_queue.push_back(hdr);
      byte_queue.push_back(8'(dx));
      if (full) byte_queue.push_back(8'(dy));
   endfunction

   // mostly well-formed packets; some stray bytes and cut-short packets
   task automatic add_random(input int count);
      int n;
      n = 0;
      @(negedge clock);
      while (n < count) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 3)) byte_queue.push_back(8'($urandom_range(0, 255)));
            1: add_packet(1'b0);
            default: begin
               add_packet(1'b1);
               n += 3;
            end
         endcase
      end
   endtask

   initial begin
      logic [7:0] opening[$] = '{
         8'h00, 8'hFF, 8'h08, 8'h55, ACK_BYTE,          // ignored until acknowledge
         8'hC8, 8'h48, 8'h88, 8'h00, ACK_BYTE,          // bad headers
         8'h09, 8'h00, 8'h00,                           // press, no motion
         8'h39, 8'h00, 8'h00,                           // held, most negative deltas
         8'h08, 8'hFF, 8'hFF,                           // release plus move
         8'h08, 8'h00, 8'h00                            // nothing to report
      };
      req.valid = 1'b0;
      req.data_byte = '0;
      rsp.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_SENS;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (opening[i]) byte_queue.push_back(opening[i]);
      add_random(60);

      settle();
      apply_setting(255, 255, 4095, 4095);
      add_random(70);
      hold_asks <= hold_asks + 1;

      settle();
      apply_setting(0, 0, 0, 0);
      add_random(50);

      settle();
      apply_setting(150, 40, 50, 30);
      add_random(70);

      settle();
      apply_setting($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
      add_random(70);

      settle();
      apply_setting(SENS_RESET, MAX_STEP_RESET, SCREEN_X_RESET, SCREEN_Y_RESET);
      add_random(60);

      while (!(byte_queue.size() == 0 && !req.valid && event_queue.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (event_queue.size() != 0) begin
         $error("%0d events never arrived", event_queue.size());
         n_fail++;
      end
      $display("run: %0d bytes, %0d events checked (%0d button, %0d move), %0d register settings",
               n_req, n_checked, n_btn_events, n_moves, n_settings);
      $display("includes a long response hold with the request side kept busy");
      if (n_fail == 0) begin
         $display("ps2_mouse_packet_tracker_unit test passed");
      end else begin
         $display("ps2_mouse_packet_tracker_unit test failed");
      end
      $finish;
   end

endmodule
